// File: rtl/core/stq_pkg.sv
// ============================================================================
// stq_pkg: shared types and constants for the sorted timer queue
// Command codes, beat structs and default sizes.
// ============================================================================
package stq_pkg;

    localparam int SlotsDefault = 16;
    localparam int TickDefault  = 32;

    localparam logic [2:0] KIND_ADVANCE = 3'd0;
    localparam logic [2:0] KIND_RUN     = 3'd1;
    localparam logic [2:0] KIND_ONESHOT = 3'd2;
    localparam logic [2:0] KIND_PERIOD  = 3'd3;
    localparam logic [2:0] KIND_STOP    = 3'd4;
    localparam logic [2:0] KIND_QUERY   = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  timer_id;
        logic [31:0] amount;
    } cmd_t;

    typedef struct packed {
        logic        fired;
        logic [3:0]  fired_timer;
        logic [31:0] remaining;
        logic        running;
    } rsp_t;

endpackage

// File: rtl/core/stq_core.sv
// ============================================================================
// stq_core: timer list sequencer
// One list entry is visited per cycle through a single shared subtract/compare.
// ============================================================================
module stq_core
    import stq_pkg::*;
#(
    parameter int TIMER_SLOTS = SlotsDefault,
    parameter int TICK_WIDTH  = TickDefault
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t result
);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int LW = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FIND   = 9'b000000010,
        S_TAKE   = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_SHIFT  = 9'b000010000,
        S_MARK   = 9'b000100000,
        S_FIRE   = 9'b001000000,
        S_REPORT = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [TIMER_SLOTS-1:0] in_list_reg, repeats_reg, due_reg;
    logic [TICK_WIDTH-1:0]  deadline_mem [TIMER_SLOTS];
    logic [TICK_WIDTH-1:0]  period_mem   [TIMER_SLOTS];
    logic [IW-1:0]          order_reg    [TIMER_SLOTS];
    logic [LW-1:0]          len_reg;
    logic [TICK_WIDTH-1:0]  gtime_reg, unproc_reg, delta_reg, last_reg;

    logic [2:0]            kind_reg;
    logic [IW-1:0]         id_reg;
    logic [LW-1:0]         pos_reg, k_reg;
    logic                  place_reg;   // after take-out, insert again
    logic                  fired_reg;
    logic [IW-1:0]         fid_reg;
    logic [TICK_WIDTH-1:0] mine_reg;
    rsp_t                  res_reg;

    // shared subtract unit: a - b, operands chosen by state
    logic [TICK_WIDTH-1:0] op_a, op_b, diff;
    logic [IW-1:0]         cur;
    logic [IW-1:0]         cmd_id;
    logic                  id_ok;

    assign cur    = order_reg[k_reg[IW-1:0]];
    assign diff   = op_a - op_b;
    assign cmd_id = IW'(cmd.timer_id);
    assign id_ok  = ({1'b0, cmd.timer_id} < 5'(TIMER_SLOTS)) || (TIMER_SLOTS >= 16);

    always_comb
    begin
        op_a = deadline_mem[cur];
        op_b = gtime_reg;
        if (state_reg == S_MARK) op_b = last_reg;
        if (state_reg == S_REPORT)
        begin
            op_a = deadline_mem[kind_reg == KIND_QUERY ? id_reg : order_reg[0]];
        end
    end

    // remaining ticks from the shared difference
    function automatic logic [TICK_WIDTH-1:0] left_f(input logic [TICK_WIDTH-1:0] r,
                                                     input logic due,
                                                     input logic [TICK_WIDTH-1:0] u);
        left_f = (!due && r > u) ? r - u : '0;
    endfunction

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_list_reg <= '0;
            repeats_reg <= '0;
            due_reg     <= '0;
            len_reg     <= '0;
            gtime_reg   <= '0;
            unproc_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg  <= cmd.kind;
                        id_reg    <= cmd_id;
                        res_reg   <= '0;
                        fired_reg <= 1'b0;
                        k_reg     <= '0;
                        place_reg <= 1'b0;
                        state_reg <= S_DONE;
                        unique case (cmd.kind) inside
                            KIND_ADVANCE:
                                unproc_reg <= unproc_reg + TICK_WIDTH'(cmd.amount);
                            KIND_RUN:
                            begin
                                delta_reg  <= unproc_reg;
                                last_reg   <= gtime_reg;
                                gtime_reg  <= gtime_reg + unproc_reg;
                                unproc_reg <= '0;
                                state_reg  <= S_MARK;
                            end
                            KIND_ONESHOT, KIND_PERIOD:
                            begin
                                if (id_ok)
                                begin
                                    repeats_reg[cmd_id] <= (cmd.kind == KIND_PERIOD);
                                    period_mem[cmd_id]  <= TICK_WIDTH'(cmd.amount);
                                    deadline_mem[cmd_id] <=
                                        gtime_reg + TICK_WIDTH'(cmd.amount) + unproc_reg;
                                    place_reg <= 1'b1;
                                    state_reg <= S_FIND;
                                end
                            end
                            KIND_STOP:
                                if (id_ok) state_reg <= S_FIND;
                            KIND_QUERY:
                                if (id_ok) state_reg <= S_REPORT;
                            default: ;
                        endcase
                    end
                end
                // locate the slot in the list
                S_FIND:
                begin
                    if (!in_list_reg[id_reg] || k_reg >= len_reg)
                    begin
                        in_list_reg[id_reg] <= 1'b0;
                        k_reg <= '0;
                        pos_reg <= '0;
                        state_reg <= place_reg ? S_SCAN :
                                     (kind_reg == KIND_RUN) ? S_REPORT : S_DONE;
                        if (place_reg) due_reg[id_reg] <= 1'b0;
                    end
                    else if (cur == id_reg) state_reg <= S_TAKE;
                    else k_reg <= k_reg + 1'b1;
                end
                // close the gap, one entry per cycle
                S_TAKE:
                begin
                    if (k_reg + 1'b1 < len_reg)
                    begin
                        order_reg[k_reg[IW-1:0]] <= order_reg[IW'(k_reg + 1'b1)];
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        len_reg <= len_reg - 1'b1;
                        in_list_reg[id_reg] <= 1'b0;
                        k_reg <= '0;
                        pos_reg <= '0;
                        state_reg <= place_reg ? S_SCAN :
                                     (kind_reg == KIND_RUN) ? S_REPORT : S_DONE;
                        if (place_reg) due_reg[id_reg] <= 1'b0;
                    end
                end
                // find the insert position; mine_reg holds the slot's own offset
                S_SCAN:
                begin
                    if (k_reg >= len_reg)
                    begin
                        k_reg <= len_reg;
                        state_reg <= S_SHIFT;
                    end
                    else if (due_reg[cur] || mine_reg >= diff)
                    begin
                        pos_reg <= k_reg + 1'b1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        k_reg <= len_reg;
                        state_reg <= S_SHIFT;
                    end
                end
                // open the gap and drop the slot in
                S_SHIFT:
                begin
                    if (k_reg > pos_reg)
                    begin
                        order_reg[k_reg[IW-1:0]] <= order_reg[IW'(k_reg - 1'b1)];
                        k_reg <= k_reg - 1'b1;
                    end
                    else
                    begin
                        order_reg[pos_reg[IW-1:0]] <= id_reg;
                        len_reg <= len_reg + 1'b1;
                        in_list_reg[id_reg] <= 1'b1;
                        state_reg <= (kind_reg == KIND_RUN) ? S_REPORT : S_DONE;
                    end
                end
                // mark leading due timers
                S_MARK:
                begin
                    if (k_reg >= len_reg) state_reg <= S_FIRE;
                    else if (due_reg[cur]) k_reg <= k_reg + 1'b1;
                    else if (diff <= delta_reg)
                    begin
                        due_reg[cur] <= 1'b1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else state_reg <= S_FIRE;
                end
                S_FIRE:
                begin
                    k_reg <= '0;
                    state_reg <= S_REPORT;
                    if (len_reg != '0 && due_reg[order_reg[0]])
                    begin
                        fired_reg <= 1'b1;
                        fid_reg   <= order_reg[0];
                        id_reg    <= order_reg[0];
                        state_reg <= S_FIND;
                        place_reg <= repeats_reg[order_reg[0]];
                        if (repeats_reg[order_reg[0]])
                            deadline_mem[order_reg[0]] <=
                                gtime_reg + period_mem[order_reg[0]];
                    end
                end
                S_REPORT:
                begin
                    state_reg <= S_DONE;
                    if (kind_reg == KIND_QUERY)
                    begin
                        res_reg.remaining <= 32'(left_f(diff, due_reg[id_reg], unproc_reg));
                        res_reg.running   <= in_list_reg[id_reg];
                    end
                    else
                    begin
                        res_reg.fired       <= fired_reg;
                        res_reg.fired_timer <= fired_reg ? 4'(fid_reg) : 4'd0;
                        res_reg.remaining   <= (len_reg == '0) ? 32'({TICK_WIDTH{1'b1}}) :
                            32'(left_f(diff, due_reg[order_reg[0]], unproc_reg));
                    end
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // own offset, held steady while the scan runs
    always_ff @(posedge clk)
    begin
        if (state_reg != S_SCAN)
            mine_reg <= deadline_mem[id_reg] - gtime_reg;
    end

endmodule

// File: rtl/core/sorted_software_timer_queue.sv
// ============================================================================
// sorted_software_timer_queue: deadline-ordered timer list, top level
// Wraps the list sequencer and exposes the command port.
// ============================================================================
//  channel | signals                   | handshake
//  command | start, busy, cmd          | beat taken when start && !busy
//  result  | done, result              | one-cycle strobe, cannot stall
//
// A command runs from a bare advance up to a periodic fire (take-out, scan,
// shift), one list entry per cycle through the
// shared subtract/compare. Reset clears flags, length and times; slot stores
// hold garbage until written. busy stays high through the result strobe.
module sorted_software_timer_queue
    import stq_pkg::*;
#(
    parameter int TIMER_SLOTS = SlotsDefault,
    parameter int TICK_WIDTH  = TickDefault
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t result
);
    stq_core #(.TIMER_SLOTS(TIMER_SLOTS), .TICK_WIDTH(TICK_WIDTH)) u_core
    (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .busy(busy), .done(done), .result(result)
    );
endmodule

// File: rtl/core/stq_checker.sv
// ============================================================================
// stq_checker: port-level checks for the timer queue
// Watches command and result beats on the top-level ports.
// ============================================================================
module stq_checker
    import stq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input cmd_t cmd,
    input logic busy,
    input logic done,
    input rsp_t result
);
    // accepted command makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("not busy after beat");
    // strobe only while busy
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
    // strobe ends the command
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after done");
    // no fired timer id without fired
    a_fid: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.fired |-> result.fired_timer == 4'd0)
        else $error("stray fired id");
    // accepted command beat carries known bits
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> !$isunknown(cmd)) else $error("unknown command beat");
endmodule

bind sorted_software_timer_queue stq_checker u_chk (.*);

// File: tb/sorted_software_timer_queue_test.sv
// ============================================================================
// sorted_software_timer_queue_test: self-checking bench for the timer queue
// Drives commands with random gaps, predicts each result from a behavioral
// copy of the ordered list and checks every strobed result in order.
// ============================================================================
`timescale 1ns / 1ps

module sorted_software_timer_queue_test;
    import stq_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    // Scoreboard: behavioral timer list plus queue of expected results
    class timer_scoreboard;
        bit          in_list [NSLOT];
        bit          repeats [NSLOT];
        bit          due [NSLOT];
        bit   [31:0] deadline [NSLOT];
        bit   [31:0] period [NSLOT];
        bit   [3:0]  order [NSLOT];
        int          length;
        bit   [31:0] group_time;
        bit   [31:0] carry_ticks;
        rsp_t        expected_rsp [$];
        int          errors;

        function void take_out(int id);
            int pos;
            pos = 0;
            if (!in_list[id])
            begin
                return;
            end
            while (pos < length && order[pos] != id)
            begin
                pos++;
            end
            for (int k = pos; k + 1 < length; k++)
            begin
                order[k] = order[k + 1];
            end
            if (pos < length)
            begin
                length--;
            end
            in_list[id] = 0;
        endfunction

        function void place(int id);
            int pos;
            bit [31:0] mine;
            bit [31:0] theirs;
            pos = 0;
            take_out(id);
            due[id] = 0;
            mine = deadline[id] - group_time;
            for (int k = 0; k < length; k++)
            begin
                theirs = deadline[order[k]] - group_time;
                if (due[order[k]] || mine >= theirs)
                begin
                    pos = k + 1;
                end
                else
                begin
                    break;
                end
            end
            for (int k = length; k > pos; k--)
            begin
                order[k] = order[k - 1];
            end
            order[pos] = 4'(id);
            length++;
            in_list[id] = 1;
        endfunction

        function bit [31:0] ticks_left(int id);
            bit [31:0] r;
            r = deadline[id] - group_time;
            if (!due[id] && r > carry_ticks)
            begin
                return r - carry_ticks;
            end
            return '0;
        endfunction

        // Note an accepted command beat and queue its expected result
        function void note_command(cmd_t c);
            rsp_t r;
            bit [31:0] delta;
            bit [31:0] last;
            int t;
            int id;
            r = '0;
            id = c.timer_id;
            case (c.kind)
                KIND_ADVANCE: carry_ticks += c.amount;
                KIND_RUN:
                begin
                    delta = carry_ticks;
                    last = group_time;
                    carry_ticks = 0;
                    group_time += delta;
                    for (int k = 0; k < length; k++)
                    begin
                        t = order[k];
                        if (due[t])
                        begin
                            continue;
                        end
                        if (deadline[t] - last <= delta)
                        begin
                            due[t] = 1;
                        end
                        else
                        begin
                            break;
                        end
                    end
                    if (length > 0 && due[order[0]])
                    begin
                        t = order[0];
                        r.fired = 1;
                        r.fired_timer = 4'(t);
                        if (repeats[t])
                        begin
                            deadline[t] = group_time + period[t];
                            place(t);
                        end
                        else
                        begin
                            take_out(t);
                        end
                    end
                    r.remaining = (length > 0) ? ticks_left(order[0]) : '1;
                end
                KIND_ONESHOT, KIND_PERIOD:
                begin
                    repeats[id] = (c.kind == KIND_PERIOD);
                    period[id] = c.amount;
                    deadline[id] = group_time + c.amount + carry_ticks;
                    place(id);
                end
                KIND_STOP: take_out(id);
                KIND_QUERY:
                begin
                    r.remaining = ticks_left(id);
                    r.running = in_list[id];
                end
                default: ;
            endcase
            expected_rsp.push_back(r);
        endfunction

        // Check one strobed result beat against the oldest expectation
        task check_result(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("unexpected result beat");
                return;
            end
            want = expected_rsp.pop_front();
            if (got.fired !== want.fired)
                report_mismatch($sformatf("fired %b exp %b", got.fired, want.fired));
            if (got.fired_timer !== want.fired_timer)
                report_mismatch($sformatf("fired_timer %0d exp %0d",
                    got.fired_timer, want.fired_timer));
            if (got.remaining !== want.remaining)
                report_mismatch($sformatf("remaining %h exp %h",
                    got.remaining, want.remaining));
            if (got.running !== want.running)
                report_mismatch($sformatf("running %b exp %b", got.running, want.running));
        endtask

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    cmd_t cmd = '0;
    logic busy;
    logic done;
    rsp_t result;

    timer_scoreboard sb = new();
    bit started [NSLOT];
    int idle_cycles = 0;

    sorted_software_timer_queue dut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .busy(busy), .done(done), .result(result)
    );

    always #2 clk = ~clk;

    // Monitor: accepted beats on both channels, plus the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_command(cmd);
            end
            if (done)
            begin
                sb.check_result(result);
            end
            idle_cycles = (done || (start && !busy)) ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Send one command beat after a random gap, hold until accepted;
    // start stays high afterwards unless a gap or a drain follows
    task send_command(logic [2:0] kind, int id, logic [31:0] amount);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        if (kind == KIND_QUERY && !started[id])
        begin
            kind = KIND_RUN;
        end
        if (kind == KIND_ONESHOT || kind == KIND_PERIOD)
        begin
            started[id] = 1;
        end
        start <= 1;
        cmd <= '{kind: kind, timer_id: id[3:0], amount: amount};
        do @(posedge clk); while (busy);
    endtask

    // Drop start and wait until every expected result has come
    task wait_drained;
        start <= 0;
        @(posedge clk);
        while (sb.expected_rsp.size() != 0) @(posedge clk);
    endtask

    function logic [31:0] pick_amount();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return 32'($urandom_range(0, 40));
        endcase
    endfunction

    initial
    begin
        int sel;
        logic [2:0] k;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty run, extremes, restart, stop, wrap, unused kinds
        send_command(KIND_RUN, 0, 0);
        send_command(KIND_ONESHOT, 0, 0);
        send_command(KIND_PERIOD, 15, 32'hFFFF_FFFF);
        send_command(KIND_ONESHOT, 3, 5);
        send_command(KIND_ONESHOT, 4, 5);
        send_command(KIND_QUERY, 15, 0);
        send_command(KIND_RUN, 0, 0);
        send_command(KIND_ADVANCE, 0, 5);
        send_command(KIND_QUERY, 3, 0);
        send_command(KIND_RUN, 0, 0);
        send_command(KIND_RUN, 0, 0);
        send_command(KIND_QUERY, 3, 0);
        send_command(KIND_PERIOD, 7, 2);
        send_command(KIND_PERIOD, 7, 3);
        send_command(KIND_STOP, 4, 0);
        send_command(KIND_STOP, 9, 0);
        send_command(KIND_ADVANCE, 0, 32'hFFFF_FFFF);
        send_command(KIND_RUN, 0, 0);
        send_command(KIND_RUN, 0, 0);
        send_command(3'd6, 5, 32'hFFFF_FFFF);
        send_command(3'd7, 10, 32'h5555_AAAA);
        send_command(KIND_QUERY, 7, 0);
        wait_drained();

        // Random: mostly starts, advances and runs over all sixteen slots
        for (int n = 0; n < 950; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 22) k = KIND_ADVANCE;
            else if (sel < 50) k = KIND_RUN;
            else if (sel < 64) k = KIND_ONESHOT;
            else if (sel < 76) k = KIND_PERIOD;
            else if (sel < 84) k = KIND_STOP;
            else if (sel < 97) k = KIND_QUERY;
            else k = 3'($urandom_range(6, 7));
            send_command(k, $urandom_range(0, 15), pick_amount());
            if (n == 500)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/stq_pkg.sv
rtl/core/stq_core.sv
rtl/core/sorted_software_timer_queue.sv
rtl/core/stq_checker.sv
tb/sorted_software_timer_queue_test.sv
